// ===== design/stdd_pkg.sv =====
// ----------------------------------------------------------------------------
// stdd_pkg - shared types and constants
// word layouts for the subscriber table, opcodes and sensor constants
// ----------------------------------------------------------------------------
package stdd_pkg;

   localparam logic [1:0] OP_SUBSCRIBE   = 2'd0;
   localparam logic [1:0] OP_UNSUBSCRIBE = 2'd1;
   localparam logic [1:0] OP_PRESS       = 2'd2;

   localparam int          NUM_SENSORS    = 3;
   localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
   localparam int          MAX_SLOTS      = 32;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [2:0]  sensor_mask;
      logic [4:0]  slot_id;
      logic [1:0]  sensor_index;
      logic [31:0] tick;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [4:0]  assigned_slot;
      logic [31:0] notify_mask;
   } rsp_type;

   // one subscriber slot as held in a cell
   typedef struct packed {
      logic       occ;
      logic [2:0] mask;
   } slot_type;

   // sequencer to chain
   typedef struct packed {
      logic     shift;
      slot_type tail;
   } chain_ctl_type;

endpackage

// ===== design/stdd_cell.sv =====
// ----------------------------------------------------------------------------
// stdd_cell - one subscriber slot of the rotating table
// holds occupancy and sensor mask, loads its neighbour's slot on shift
// ----------------------------------------------------------------------------
module stdd_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  stdd_pkg::slot_type nbr_slot,
   output stdd_pkg::slot_type slot
);
   import stdd_pkg::*;

   logic       occ_ff;
   logic [2:0] mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else if (shift) begin
         occ_ff <= nbr_slot.occ;
      end
   end

   // mask is only meaningful once written
   always_ff @(posedge clock) begin
      if (shift) begin
         mask_ff <= nbr_slot.mask;
      end
   end

   assign slot.occ  = occ_ff;
   assign slot.mask = mask_ff;

endmodule

// ===== design/stdd_seq.sv =====
// ----------------------------------------------------------------------------
// stdd_seq - walk sequencer
// takes one word, watches the head cell for one full rotation, writes back
// the modified slot at the tail and issues the result word
// ----------------------------------------------------------------------------
module stdd_seq #(
   parameter int SLOT_COUNT = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  stdd_pkg::req_type       req,
   input  logic [15:0]             debounce,
   input  stdd_pkg::slot_type      head,
   output stdd_pkg::chain_ctl_type ctl,
   output logic                    rsp_valid,
   output stdd_pkg::rsp_type       rsp
);
   import stdd_pkg::*;

   localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   typedef enum logic {ST_IDLE, ST_WALK} state_type;

   state_type      state_ff;
   req_type        req_ff;
   logic           hit_ff;
   logic [2:0]     sel_ff;
   logic [IdxW-1:0] idx_ff;
   logic           found_ff;
   logic [4:0]     slot_ff;
   logic [31:0]    notify_ff;
   logic [31:0]    last_ff [NUM_SENSORS];
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;

   logic           found_in;
   logic [4:0]     slot_in;
   logic [31:0]    notify_in;
   logic           hit_in;
   logic           sensor_ok;
   logic [31:0]    last_sel;
   logic [31:0]    diff;
   logic           last_step;
   slot_type       tail;

   // debounce check on the incoming word
   always_comb begin
      sensor_ok = (req.sensor_index < 2'(NUM_SENSORS));
      last_sel  = sensor_ok ? last_ff[req.sensor_index] : '0;
      diff      = req.tick - last_sel;
      hit_in    = (req.opcode == OP_PRESS) && sensor_ok && (diff > {16'b0, debounce});
   end

   assign last_step = (idx_ff == IdxW'(SLOT_COUNT - 1));

   always_comb begin
      tail      = head;
      found_in  = found_ff;
      slot_in   = slot_ff;
      notify_in = notify_ff;
      if (state_ff == ST_WALK) begin
         unique case (req_ff.opcode)
            OP_SUBSCRIBE: begin
               if (!found_ff && !head.occ) begin
                  tail.occ  = 1'b1;
                  tail.mask = req_ff.sensor_mask;
                  found_in  = 1'b1;
                  slot_in   = 5'(idx_ff);
               end
            end
            OP_UNSUBSCRIBE: begin
               if (6'(idx_ff) == {1'b0, req_ff.slot_id}) begin
                  tail.occ = 1'b0;
               end
            end
            OP_PRESS: begin
               if (hit_ff && head.occ && ((head.mask & sel_ff) != 3'b000)) begin
                  notify_in[idx_ff] = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < NUM_SENSORS; s++) begin
            last_ff[s] <= '0;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  req_ff    <= req;
                  hit_ff    <= hit_in;
                  sel_ff    <= 3'(3'b001 << req.sensor_index);
                  idx_ff    <= '0;
                  found_ff  <= 1'b0;
                  slot_ff   <= '0;
                  notify_ff <= '0;
                  state_ff  <= ST_WALK;
               end
            end
            ST_WALK: begin
               idx_ff    <= idx_ff + 1'b1;
               found_ff  <= found_in;
               slot_ff   <= slot_in;
               notify_ff <= notify_in;
               if (last_step) begin
                  state_ff             <= ST_IDLE;
                  rsp_valid_ff         <= 1'b1;
                  rsp_ff.status        <= (req_ff.opcode == OP_SUBSCRIBE) && !found_in;
                  rsp_ff.assigned_slot <= found_in ? slot_in : 5'd0;
                  rsp_ff.notify_mask   <= notify_in;
                  if (notify_in != 32'd0) begin
                     last_ff[req_ff.sensor_index] <= req_ff.tick;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff == ST_WALK);
   assign ctl.shift = (state_ff == ST_WALK);
   assign ctl.tail  = tail;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== design/subscriber_table_debounce_dispatch.sv =====
// a word accepted while idle is walked once round the whole slot chain, one
// step per slot, and its result word is registered at the end of the walk;
// no new word is taken while busy is high, so words are handled one at a time
// the receiver cannot stall: rsp_valid is a single-cycle strobe
// reset (synchronous, active high) frees all slots, clears the sensor times
// and loads debounce_ticks with 50; slot masks are left as they are
// ----------------------------------------------------------------------------
// subscriber_table_debounce_dispatch - top level
// subscriber table with per-sensor debounce and notify dispatch
// ----------------------------------------------------------------------------
module subscriber_table_debounce_dispatch #(
   parameter int SLOTS = 32
) (
   input  logic              clock,
   input  logic              reset,
   // command word
   input  logic              start,
   output logic              busy,
   input  stdd_pkg::req_type req_data,
   // result word
   output logic              rsp_valid,
   output stdd_pkg::rsp_type rsp_data,
   // debounce register
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data
);
   import stdd_pkg::*;

   // slot numbers and notify masks only cover 32 slots
   localparam int SlotCount = (SLOTS < MAX_SLOTS) ? SLOTS : MAX_SLOTS;

   logic [15:0]   debounce_ff;
   chain_ctl_type ctl;
   slot_type      cell_q [SlotCount];

   // debounce_ticks, to be written only while idle; the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
      end else if (csr_wr_en) begin
         debounce_ff <= csr_wr_data;
      end
   end

   // slot chain: each cell takes its upper neighbour, the last cell takes
   // the head slot as modified by the sequencer; one walk of SlotCount
   // shifts brings every slot back to its own cell
   for (genvar g = 0; g < SlotCount; g++) begin : g_cell
      if (g == SlotCount - 1) begin : g_tail
         stdd_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (ctl.shift),
            .nbr_slot (ctl.tail),
            .slot     (cell_q[g])
         );
      end else begin : g_body
         stdd_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (ctl.shift),
            .nbr_slot (cell_q[g+1]),
            .slot     (cell_q[g])
         );
      end
   end

   // sequencer sees slot number idx at the head on step idx of the walk
   stdd_seq #(
      .SLOT_COUNT (SlotCount)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req_data),
      .debounce  (debounce_ff),
      .head      (cell_q[0]),
      .ctl       (ctl),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

`ifndef SYNTHESIS
   // an accepted word always starts a walk
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not start a walk");

   // a result word appears only once the walk is over
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result issued during a walk");

   // strobe lasts exactly one cycle
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // table full answers carry no slot and no notify bits
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |->
         (rsp_data.assigned_slot == 5'd0 && rsp_data.notify_mask == 32'd0))
      else $error("table full word carries data");
`endif

endmodule
